[rtl/dcp_pkg.sv]
// Shared types, constants and register codes for the critical-path length block.
package dcp_pkg;

	localparam int ACTIVITY_COUNT = 64;
	localparam int IDX_W          = $clog2(ACTIVITY_COUNT);
	localparam int PRED_SLOTS     = 4;
	localparam int LEN_W          = 16;
	localparam int DUR_W          = 8;
	localparam int CNT_W          = 3;
	localparam int ADDR_W         = 3;
	localparam int DATA_W         = 32;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [LEN_W-1:0] len_t;
	typedef logic [DUR_W-1:0] dur_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam len_t LENGTH_MAX = '1;
	localparam len_t MIN_LENGTH = len_t'(1);

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_RANGE_START  = 1'b0,
		REG_RANGE_FINISH = 1'b1
	} reg_idx_t;

	localparam idx_t RANGE_START_RST  = '0;
	localparam idx_t RANGE_FINISH_RST = idx_t'(ACTIVITY_COUNT - 1);

	typedef struct packed {
		idx_t range_start;
		idx_t range_finish;
	} cfg_t;

	typedef struct packed {
		logic en;
		idx_t addr;
		len_t data;
	} wr_t;

endpackage

[rtl/dcp_regs.sv]
// APB-style configuration registers: range start and range finish.
module dcp_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [dcp_pkg::ADDR_W-1:0] paddr,
	input  logic [dcp_pkg::DATA_W-1:0] pwdata,
	output logic [dcp_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output dcp_pkg::cfg_t              cfg
);

	dcp_pkg::idx_t     range_start_q;
	dcp_pkg::idx_t     range_finish_q;
	dcp_pkg::reg_idx_t sel;
	logic              wr_en;

	assign pready = 1'b1;
	assign sel    = dcp_pkg::reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_start_q  <= dcp_pkg::RANGE_START_RST;
			range_finish_q <= dcp_pkg::RANGE_FINISH_RST;
		end else if (wr_en) begin
			unique case (sel)
				dcp_pkg::REG_RANGE_START:  range_start_q  <= pwdata[dcp_pkg::IDX_W-1:0];
				dcp_pkg::REG_RANGE_FINISH: range_finish_q <= pwdata[dcp_pkg::IDX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (sel)
			dcp_pkg::REG_RANGE_START:  prdata[dcp_pkg::IDX_W-1:0] = range_start_q;
			dcp_pkg::REG_RANGE_FINISH: prdata[dcp_pkg::IDX_W-1:0] = range_finish_q;
			default: prdata = '0;
		endcase
	end

	assign cfg.range_start  = range_start_q;
	assign cfg.range_finish = range_finish_q;

endmodule

[rtl/dcp_lane.sv]
// One predecessor lane: private copy of the path store and candidate select.
module dcp_lane (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  dcp_pkg::idx_t rd_addr,
	input  logic          hit,
	input  logic          fwd,
	input  dcp_pkg::wr_t  wr,
	input  dcp_pkg::len_t fwd_len,
	output dcp_pkg::len_t cand
);

	dcp_pkg::len_t mem [dcp_pkg::ACTIVITY_COUNT];
	dcp_pkg::len_t rd_s1;
	logic          hit_s1;
	logic          fwd_s1;

	// every lane sees the same writes, so all copies stay identical
	always_ff @(posedge clk) begin
		if (wr.en)
			mem[wr.addr] <= wr.data;
		if (rd_en)
			rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (rd_en) begin
			hit_s1 <= hit;
			fwd_s1 <= fwd;
		end
	end

	// take the length written on the accept edge when the read missed it
	always_comb begin
		if (!hit_s1)
			cand = '0;
		else if (fwd_s1)
			cand = fwd_len;
		else
			cand = rd_s1;
	end

endmodule

[rtl/dcp_merge.sv]
// Merge of the lane candidates: maximum, plus duration, saturated.
module dcp_merge (
	input  dcp_pkg::len_t cand [dcp_pkg::PRED_SLOTS],
	input  dcp_pkg::dur_t duration,
	output dcp_pkg::len_t sum
);

	dcp_pkg::len_t           best;
	logic [dcp_pkg::LEN_W:0] wide;

	always_comb begin
		best = '0;
		for (int p = 0; p < dcp_pkg::PRED_SLOTS; p++) begin
			if (cand[p] > best)
				best = cand[p];
		end
	end

	assign wide = {1'b0, best} + {{(dcp_pkg::LEN_W + 1 - dcp_pkg::DUR_W){1'b0}}, duration};
	assign sum  = wide[dcp_pkg::LEN_W] ? dcp_pkg::LENGTH_MAX : wide[dcp_pkg::LEN_W-1:0];

endmodule

[rtl/dag_critical_path_length.sv]
// Top level of the critical-path length block: lanes, merge, marks and handshake.
//
//  channel   direction  handshake                    beat payload
//  in        receive    in_valid / in_stall          activity, duration, pred_num, pred_a..d
//  out       send       out_valid / out_stall        path_length
//  cfg       APB        psel, penable, pwrite/pready range_start (0x0), range_finish (0x4)
//
// One beat per cycle while in_stall is low. A beat is read from the four lane store copies on its
// accept edge and is merged, written back and marked from the stage-1 registers; a result sits in
// the output register until taken. A length written on the same edge is forwarded.
// Reset clears the written marks, the pipeline and the output valid; the store needs no clearing.
// in_stall rises only while a finishing beat waits behind a stalled, full output register.
module dag_critical_path_length (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [dcp_pkg::ADDR_W-1:0] paddr,
	input  logic [dcp_pkg::DATA_W-1:0] pwdata,
	output logic [dcp_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  dcp_pkg::idx_t              activity,
	input  dcp_pkg::dur_t              duration,
	input  dcp_pkg::cnt_t              pred_num,
	input  dcp_pkg::idx_t              pred_a,
	input  dcp_pkg::idx_t              pred_b,
	input  dcp_pkg::idx_t              pred_c,
	input  dcp_pkg::idx_t              pred_d,
	output logic                       out_valid,
	input  logic                       out_stall,
	output dcp_pkg::len_t              path_length
);

	dcp_pkg::cfg_t cfg;
	dcp_pkg::idx_t pred [dcp_pkg::PRED_SLOTS];
	dcp_pkg::len_t cand [dcp_pkg::PRED_SLOTS];
	logic [dcp_pkg::PRED_SLOTS-1:0] hit;
	logic [dcp_pkg::PRED_SLOTS-1:0] fwd;
	logic [dcp_pkg::ACTIVITY_COUNT-1:0] marks_q;

	logic          s1_valid;
	dcp_pkg::idx_t act_s1;
	dcp_pkg::dur_t dur_s1;
	logic          start_s1;
	logic          finish_s1;
	dcp_pkg::len_t fwd_len_s1;
	dcp_pkg::len_t sum;
	dcp_pkg::wr_t  wr;

	logic          out_valid_q;
	dcp_pkg::len_t path_length_q;

	logic s1_adv;
	logic accept;
	logic in_range;
	logic is_start;
	logic is_finish;

	dcp_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	assign pred[0] = pred_a;
	assign pred[1] = pred_b;
	assign pred[2] = pred_c;
	assign pred[3] = pred_d;

	// hold the finishing beat while the output register cannot take it
	assign s1_adv   = !s1_valid || !finish_s1 || !out_valid_q || !out_stall;
	assign in_stall = !s1_adv;
	assign accept   = in_valid && !in_stall;

	assign in_range  = (activity >= cfg.range_start) && (activity <= cfg.range_finish);
	assign is_start  = (activity == cfg.range_start);
	assign is_finish = (activity == cfg.range_finish);

	assign wr.en   = s1_valid && s1_adv;
	assign wr.addr = act_s1;
	assign wr.data = sum;

	// marks as seen after the write on this edge and after this beat's own range-start clear
	always_comb begin
		for (int p = 0; p < dcp_pkg::PRED_SLOTS; p++) begin
			logic active;
			logic pred_in;
			logic same;
			logic mark;
			active  = pred_num > dcp_pkg::cnt_t'(p);
			pred_in = (pred[p] >= cfg.range_start) && (pred[p] <= cfg.range_finish);
			same    = wr.en && (pred[p] == act_s1);
			mark    = same || (!(wr.en && start_s1) && marks_q[pred[p]]);
			hit[p]  = active && pred_in && mark && !is_start;
			fwd[p]  = same;
		end
	end

	for (genvar g = 0; g < dcp_pkg::PRED_SLOTS; g++) begin : g_lane
		dcp_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.rd_en  (accept),
			.rd_addr(pred[g]),
			.hit    (hit[g]),
			.fwd    (fwd[g]),
			.wr     (wr),
			.fwd_len(fwd_len_s1),
			.cand   (cand[g])
		);
	end

	dcp_merge u_merge (
		.cand    (cand),
		.duration(dur_s1),
		.sum     (sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid  <= 1'b0;
			start_s1  <= 1'b0;
			finish_s1 <= 1'b0;
		end else if (s1_adv) begin
			// drop beats outside the range here
			s1_valid  <= accept && in_range;
			start_s1  <= is_start;
			finish_s1 <= is_finish;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1     <= activity;
			dur_s1     <= duration;
			fwd_len_s1 <= sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marks_q <= '0;
		end else if (wr.en) begin
			if (start_s1)
				marks_q <= '0;
			marks_q[act_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wr.en && finish_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && finish_s1)
			path_length_q <= (sum == '0) ? dcp_pkg::MIN_LENGTH : sum;
	end

	assign out_valid   = out_valid_q;
	assign path_length = path_length_q;

endmodule

[tb/tb_dag_critical_path_length.sv]
// Self-checking testbench for the critical-path length block: directed table, then random chains.
module tb_dag_critical_path_length;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		dcp_pkg::idx_t act;
		dcp_pkg::dur_t dur;
		dcp_pkg::cnt_t cnt;
		dcp_pkg::idx_t pa;
		dcp_pkg::idx_t pb;
		dcp_pkg::idx_t pc;
		dcp_pkg::idx_t pd;
	} beat_t;

	typedef struct packed {
		bit            set_range;
		dcp_pkg::idx_t lo;
		dcp_pkg::idx_t hi;
		dcp_pkg::idx_t act;
		dcp_pkg::dur_t dur;
		dcp_pkg::cnt_t cnt;
		dcp_pkg::idx_t pa;
		dcp_pkg::idx_t pb;
		dcp_pkg::idx_t pc;
		dcp_pkg::idx_t pd;
		bit            typed;
		dcp_pkg::len_t want;
	} row_t;

	logic                       clk        = 1'b0;
	logic                       arst_n     = 1'b0;
	logic                       psel       = 1'b0;
	logic                       penable    = 1'b0;
	logic                       pwrite     = 1'b0;
	logic [dcp_pkg::ADDR_W-1:0] paddr      = '0;
	logic [dcp_pkg::DATA_W-1:0] pwdata     = '0;
	logic [dcp_pkg::DATA_W-1:0] prdata;
	logic                       pready;
	logic                       in_valid   = 1'b0;
	logic                       in_stall;
	dcp_pkg::idx_t              activity   = '0;
	dcp_pkg::dur_t              duration   = '0;
	dcp_pkg::cnt_t              pred_num   = '0;
	dcp_pkg::idx_t              pred_a     = '0;
	dcp_pkg::idx_t              pred_b     = '0;
	dcp_pkg::idx_t              pred_c     = '0;
	dcp_pkg::idx_t              pred_d     = '0;
	logic                       out_valid;
	logic                       out_stall  = 1'b0;
	dcp_pkg::len_t              path_length;

	// predictor state
	dcp_pkg::len_t path_len_of [dcp_pkg::ACTIVITY_COUNT];
	bit            marked_now [dcp_pkg::ACTIVITY_COUNT];
	dcp_pkg::idx_t win_start  = dcp_pkg::RANGE_START_RST;
	dcp_pkg::idx_t win_finish = dcp_pkg::RANGE_FINISH_RST;

	dcp_pkg::len_t pending_lengths [$];
	dcp_pkg::len_t head_len;
	int   mismatches   = 0;
	int   window_items = 0;
	int   range_pick   = 0;
	int   send_idle    = 0;
	int   recv_stall   = 0;
	int   idle_plan [4]  = '{0, 74, 0, 27};
	int   stall_plan [4] = '{0, 0, 74, 27};

	// set_range lo hi | act dur cnt pa pb pc pd | typed want
	row_t plan [20] = '{
		'{1'b1, 6'd0,  6'd63, 6'd0,  8'd0,   3'd0, 6'd0,  6'd0,  6'd0,  6'd0,  1'b0, 16'd0},
		'{1'b0, 6'd0,  6'd0,  6'd1,  8'd255, 3'd4, 6'd0,  6'd0,  6'd0,  6'd0,  1'b0, 16'd0},
		'{1'b0, 6'd0,  6'd0,  6'd2,  8'd255, 3'd7, 6'd1,  6'd1,  6'd1,  6'd1,  1'b0, 16'd0},
		'{1'b0, 6'd0,  6'd0,  6'd2,  8'd10,  3'd1, 6'd2,  6'd63, 6'd63, 6'd63, 1'b0, 16'd0},
		'{1'b0, 6'd0,  6'd0,  6'd5,  8'd0,   3'd4, 6'd63, 6'd62, 6'd61, 6'd60, 1'b0, 16'd0},
		'{1'b0, 6'd0,  6'd0,  6'd63, 8'd0,   3'd1, 6'd5,  6'd0,  6'd0,  6'd0,  1'b1, 16'd1},
		'{1'b1, 6'd20, 6'd30, 6'd19, 8'd100, 3'd0, 6'd0,  6'd0,  6'd0,  6'd0,  1'b0, 16'd0},
		'{1'b0, 6'd0,  6'd0,  6'd20, 8'd5,   3'd2, 6'd19, 6'd31, 6'd0,  6'd0,  1'b0, 16'd0},
		'{1'b0, 6'd0,  6'd0,  6'd25, 8'd7,   3'd1, 6'd20, 6'd0,  6'd0,  6'd0,  1'b0, 16'd0},
		'{1'b0, 6'd0,  6'd0,  6'd30, 8'd1,   3'd3, 6'd25, 6'd20, 6'd40, 6'd0,  1'b0, 16'd0},
		'{1'b0, 6'd0,  6'd0,  6'd31, 8'd9,   3'd0, 6'd0,  6'd0,  6'd0,  6'd0,  1'b0, 16'd0},
		'{1'b1, 6'd40, 6'd35, 6'd40, 8'd1,   3'd0, 6'd0,  6'd0,  6'd0,  6'd0,  1'b0, 16'd0},
		'{1'b0, 6'd0,  6'd0,  6'd35, 8'd1,   3'd1, 6'd40, 6'd0,  6'd0,  6'd0,  1'b0, 16'd0},
		'{1'b1, 6'd63, 6'd63, 6'd63, 8'd255, 3'd1, 6'd63, 6'd0,  6'd0,  6'd0,  1'b1, 16'd255},
		'{1'b0, 6'd0,  6'd0,  6'd63, 8'd255, 3'd1, 6'd63, 6'd0,  6'd0,  6'd0,  1'b1, 16'd255},
		'{1'b1, 6'd0,  6'd0,  6'd0,  8'd0,   3'd0, 6'd0,  6'd0,  6'd0,  6'd0,  1'b1, 16'd1},
		'{1'b0, 6'd0,  6'd0,  6'd0,  8'd200, 3'd2, 6'd0,  6'd0,  6'd0,  6'd0,  1'b1, 16'd200},
		'{1'b1, 6'd0,  6'd63, 6'd0,  8'd1,   3'd0, 6'd0,  6'd0,  6'd0,  6'd0,  1'b0, 16'd0},
		'{1'b0, 6'd0,  6'd0,  6'd62, 8'd255, 3'd6, 6'd0,  6'd0,  6'd0,  6'd0,  1'b0, 16'd0},
		'{1'b0, 6'd0,  6'd0,  6'd63, 8'd255, 3'd5, 6'd62, 6'd1,  6'd2,  6'd3,  1'b0, 16'd0}
	};

	dag_critical_path_length dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.activity    (activity),
		.duration    (duration),
		.pred_num    (pred_num),
		.pred_a      (pred_a),
		.pred_b      (pred_b),
		.pred_c      (pred_c),
		.pred_d      (pred_d),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.path_length (path_length)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic void predict_path_length(input beat_t b, output bit fires,
			output dcp_pkg::len_t len);
		dcp_pkg::idx_t slot [dcp_pkg::PRED_SLOTS];
		int            used;
		int            k;
		int unsigned   best;
		int unsigned   total;
		fires = 1'b0;
		len   = '0;
		if (b.act < win_start || b.act > win_finish)
			return;
		// a beat at the range start opens a new run
		if (b.act == win_start)
			foreach (marked_now[m]) marked_now[m] = 1'b0;
		slot = '{b.pa, b.pb, b.pc, b.pd};
		used = (b.cnt > dcp_pkg::PRED_SLOTS) ? dcp_pkg::PRED_SLOTS : int'(b.cnt);
		best = 0;
		for (k = 0; k < used; k++) begin
			if (slot[k] >= win_start && slot[k] <= win_finish && marked_now[slot[k]] &&
					path_len_of[slot[k]] > best)
				best = path_len_of[slot[k]];
		end
		total = best + b.dur;
		if (total > dcp_pkg::LENGTH_MAX)
			total = dcp_pkg::LENGTH_MAX;
		path_len_of[b.act] = dcp_pkg::len_t'(total);
		marked_now[b.act]  = 1'b1;
		if (b.act == win_finish) begin
			fires = 1'b1;
			len   = (total == 0) ? dcp_pkg::MIN_LENGTH : dcp_pkg::len_t'(total);
		end
	endfunction

	task automatic send_beat(input beat_t b, input bit typed, input dcp_pkg::len_t want);
		bit            fires;
		dcp_pkg::len_t len;
		if (send_idle != 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		in_valid   <= 1'b1;
		activity   <= b.act;
		duration   <= b.dur;
		pred_num   <= b.cnt;
		pred_a     <= b.pa;
		pred_b     <= b.pb;
		pred_c     <= b.pc;
		pred_d     <= b.pd;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (b.act >= win_start && b.act <= win_finish)
			window_items++;
		predict_path_length(b, fires, len);
		if (fires)
			pending_lengths.push_back(typed ? want : len);
	endtask

	// drop valid and hold until every pending length is out, then wait out the pipe
	task automatic settle(input int tail);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_lengths.size() != 0);
		repeat (tail) @(posedge clk);
	endtask

	task automatic program_reg(input dcp_pkg::reg_idx_t r, input dcp_pkg::idx_t v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= dcp_pkg::ADDR_W'({r, 2'b00});
		pwdata  <= dcp_pkg::DATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		// turn straight into a read of the same register
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== dcp_pkg::DATA_W'(v))
			report_mismatch("register readback", prdata, dcp_pkg::DATA_W'(v));
		psel    <= 1'b0;
		penable <= 1'b0;
		case (r)
			dcp_pkg::REG_RANGE_START:  win_start  = v;
			dcp_pkg::REG_RANGE_FINISH: win_finish = v;
		endcase
	endtask

	function automatic dcp_pkg::dur_t pick_duration();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return '1;
		if (r < 15)
			return '0;
		return dcp_pkg::dur_t'($urandom_range(255));
	endfunction

	function automatic dcp_pkg::idx_t pick_pred(input int lo, input int a);
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return dcp_pkg::idx_t'($urandom_range(a, lo));
		if (r < 75)
			return dcp_pkg::idx_t'($urandom_range(win_finish, lo));
		return dcp_pkg::idx_t'($urandom_range(63));
	endfunction

	function automatic beat_t noise_beat();
		logic [63:0] raw;
		beat_t       b;
		raw = {$urandom, $urandom};
		b   = raw[$bits(beat_t)-1:0];
		return b;
	endfunction

	// ascending chain of activities with random content; interior beats may be skipped
	task automatic run_chain(input int first, input int last);
		beat_t b;
		int    a;
		for (a = first; a <= last; a++) begin
			if (a != first && a != last && $urandom_range(99) < 15)
				continue;
			b.act = dcp_pkg::idx_t'(a);
			b.dur = pick_duration();
			b.cnt = dcp_pkg::cnt_t'($urandom_range(7));
			b.pa  = pick_pred(first, a);
			b.pb  = pick_pred(first, a);
			b.pc  = pick_pred(first, a);
			b.pd  = pick_pred(first, a);
			send_beat(b, 1'b0, '0);
		end
	endtask

	task automatic random_phase(input int quota);
		int target;
		int goal;
		int sel;
		int s;
		int f;
		target = window_items + quota;
		while (window_items < target) begin
			case (range_pick % 8)
				0: begin s = 0; f = 63; end
				1: begin s = 0; f = 0; end
				2: begin s = 63; f = 63; end
				3: begin
					s = $urandom_range(63, 1);
					f = $urandom_range(s - 1, 0);
				end
				default: begin
					s = $urandom_range(63);
					f = s + $urandom_range(12);
					if (f > 63)
						f = 63;
				end
			endcase
			range_pick++;
			settle(4);
			program_reg(dcp_pkg::REG_RANGE_START, dcp_pkg::idx_t'(s));
			program_reg(dcp_pkg::REG_RANGE_FINISH, dcp_pkg::idx_t'(f));
			if (s > f) begin
				repeat (12) send_beat(noise_beat(), 1'b0, '0);
			end else begin
				goal = window_items + 60;
				while (window_items < goal) begin
					sel = $urandom_range(99);
					if (sel < 3)
						settle(0);
					if (sel < 70)
						run_chain(s, f);
					else if (sel < 85)
						repeat (4) send_beat(noise_beat(), 1'b0, '0);
					else if (sel < 93 && s < f)
						run_chain(s + 1, f);
					else
						run_chain(s, $urandom_range(f, s));
				end
			end
		end
	endtask

	always @(posedge clk)
		out_stall <= (recv_stall != 0) && ($urandom_range(99) < recv_stall);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_lengths.size() == 0) begin
				report_mismatch("path_length with none pending", 32'(path_length), 32'd0);
			end else begin
				head_len = pending_lengths.pop_front();
				if (path_length !== head_len)
					report_mismatch("path_length", 32'(path_length), 32'(head_len));
			end
		end
	end

	initial begin
		beat_t b;
		int    i;
		int    ph;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// write every store entry once, as a chain over the reset range
		for (i = 0; i < dcp_pkg::ACTIVITY_COUNT; i++) begin
			b.act = dcp_pkg::idx_t'(i);
			b.dur = dcp_pkg::dur_t'($urandom_range(255));
			b.cnt = dcp_pkg::cnt_t'(4);
			b.pa  = dcp_pkg::idx_t'((i == 0) ? 0 : i - 1);
			b.pb  = b.pa;
			b.pc  = b.pa;
			b.pd  = b.pa;
			send_beat(b, 1'b0, '0);
		end
		foreach (plan[k]) begin
			if (plan[k].set_range) begin
				settle(4);
				program_reg(dcp_pkg::REG_RANGE_START, plan[k].lo);
				program_reg(dcp_pkg::REG_RANGE_FINISH, plan[k].hi);
			end
			b = '{plan[k].act, plan[k].dur, plan[k].cnt, plan[k].pa, plan[k].pb,
				plan[k].pc, plan[k].pd};
			send_beat(b, plan[k].typed, plan[k].want);
		end
		// climb one activity onto itself until the length saturates
		b = '{6'd0, 8'd255, 3'd0, 6'd0, 6'd0, 6'd0, 6'd0};
		send_beat(b, 1'b0, '0);
		b = '{6'd10, 8'd255, 3'd4, 6'd10, 6'd10, 6'd10, 6'd10};
		repeat (300) send_beat(b, 1'b0, '0);
		b = '{6'd63, 8'd255, 3'd2, 6'd10, 6'd62, 6'd0, 6'd0};
		send_beat(b, 1'b1, dcp_pkg::LENGTH_MAX);
		for (ph = 0; ph < 4; ph++) begin
			send_idle  = idle_plan[ph];
			recv_stall = stall_plan[ph];
			random_phase(260);
		end
		settle(8);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

[dag_critical_path_length.f]
rtl/dcp_pkg.sv
rtl/dcp_regs.sv
rtl/dcp_lane.sv
rtl/dcp_merge.sv
rtl/dag_critical_path_length.sv
tb/tb_dag_critical_path_length.sv
